[hw/rtl/sbq_pkg.sv]
// Package for the sorted bounded queue: sizes, codes and the command and
// status structs between the controller and the datapath. No dependencies.
package sbq_pkg;

   localparam int CAPACITY   = 10;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int KEY_W      = 64;
   localparam int PAY_W      = 64;
   localparam int FILL_W     = 4;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 136;

   typedef enum logic {
      ACT_PUSH = 1'b0,
      ACT_POP  = 1'b1
   } act_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
   } stat_type;

endpackage

[hw/rtl/sorted_bounded_queue.sv]
// Top level of the sorted bounded queue: joins the controller and the
// datapath. Depends on sbq_pkg, sbq_controller and sbq_datapath.
//
//   channel  dir  tdata (low bit up)                      tuser
//   req_     in   key[63:0], payload[127:64]              action
//   rsp_     out  popped_key, popped_payload, fill, pad   status
//
// Each beat is first registered as a request; then the new key is compared
// against every held entry at once and the row of cells is shifted.
// The next request beat is taken while a response still waits for rsp_tready.
// A stalled response holds the execute step until the response register frees.
// Reset empties the queue; entry contents are left as they are.
module sorted_bounded_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // key, payload
   input  logic [sbq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // popped_key, popped_payload, fill, zero padding
   output logic [sbq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [sbq_pkg::STATUS_W-1:0]     rsp_tuser
);
   import sbq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sbq_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sbq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTH
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in progress");

   a_full_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_FULL)) |->
      (rsp_tdata[KEY_W+PAY_W+FILL_W-1:KEY_W+PAY_W] == FILL_W'(CAPACITY)))
      else $error("full refusal with fill below capacity");

   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_EMPTY)) |->
      (rsp_tdata[KEY_W+PAY_W+FILL_W-1:0] == '0))
      else $error("empty refusal with nonzero fill or data");
`endif

endmodule

[hw/rtl/sbq_controller.sv]
// Controller for the sorted bounded queue: takes one request beat, then
// applies it once the response register is free. Depends on sbq_pkg.
module sbq_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sbq_pkg::stat_type stat,
   output sbq_pkg::cmd_type  cmd
);
   import sbq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = stat.slot_free;
            if (stat.slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/sbq_datapath.sv]
// Datapath for the sorted bounded queue: request register, the row of sorted
// entry cells with their compare-and-shift logic, and the response register.
// Depends on sbq_pkg.
module sbq_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  sbq_pkg::cmd_type                 cmd,
   output sbq_pkg::stat_type                stat,
   input  logic                             req_tuser,
   input  logic [sbq_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sbq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [sbq_pkg::STATUS_W-1:0]     rsp_tuser
);
   import sbq_pkg::*;

   act_type            act_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [PAY_W-1:0]   pay_ff;

   logic [KEY_W-1:0]   keys_ff [CAPACITY];
   logic [PAY_W-1:0]   pays_ff [CAPACITY];
   logic [KEY_W-1:0]   keys_in [CAPACITY];
   logic [PAY_W-1:0]   pays_in [CAPACITY];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;
   logic [KEY_W-1:0]   rsp_key_ff;
   logic [KEY_W-1:0]   rsp_key_in;
   logic [PAY_W-1:0]   rsp_pay_ff;
   logic [PAY_W-1:0]   rsp_pay_in;
   logic [FILL_W-1:0]  rsp_fill_ff;

   logic [CAPACITY-1:0] gt;
   logic [CAPACITY-1:0] gt_prev;
   logic                full;
   logic                empty;

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // A cell holds a key greater than the new one: it and all above it move up.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (keys_ff[i] > key_ff);
      end
      gt_prev[0] = 1'b0;
      for (int i = 1; i < CAPACITY; i++) begin
         gt_prev[i] = gt[i-1];
      end
   end

   always_comb begin
      keys_in       = keys_ff;
      pays_in       = pays_ff;
      count_in      = count_ff;
      rsp_status_in = STATUS_DONE;
      rsp_key_in    = '0;
      rsp_pay_in    = '0;
      if (act_ff == ACT_PUSH) begin
         if (full) begin
            rsp_status_in = STATUS_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
            for (int i = 0; i < CAPACITY; i++) begin
               if (gt_prev[i]) begin
                  keys_in[i] = keys_ff[i-1];
                  pays_in[i] = pays_ff[i-1];
               end else if (gt[i] || (count_ff == CNT_W'(i))) begin
                  keys_in[i] = key_ff;
                  pays_in[i] = pay_ff;
               end
            end
         end
      end else begin
         if (empty) begin
            rsp_status_in = STATUS_EMPTY;
         end else begin
            count_in   = count_ff - CNT_W'(1);
            rsp_key_in = keys_ff[0];
            rsp_pay_in = pays_ff[0];
            for (int i = 0; i < CAPACITY - 1; i++) begin
               keys_in[i] = keys_ff[i+1];
               pays_in[i] = pays_ff[i+1];
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign stat.slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.execute) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= act_type'(req_tuser);
         key_ff <= req_tdata[KEY_W-1:0];
         pay_ff <= req_tdata[KEY_W+PAY_W-1:KEY_W];
      end
      if (cmd.execute) begin
         keys_ff       <= keys_in;
         pays_ff       <= pays_in;
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_pay_ff    <= rsp_pay_in;
         rsp_fill_ff   <= FILL_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - KEY_W - PAY_W - FILL_W){1'b0}},
                        rsp_fill_ff, rsp_pay_ff, rsp_key_ff};

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for sorted_bounded_queue; needs sbq_pkg. It holds a
// sorted queue model and checks every response beat against it or a typed row.
module tb;
   import sbq_pkg::*;

   typedef struct {
      status_type    status;
      logic [63:0]   key;
      logic [63:0]   pay;
      logic [3:0]    fill;
   } queue_rsp_type;

   typedef struct {
      act_type       act;
      logic [63:0]   key;
      logic [63:0]   pay;
      bit            typed;
      queue_rsp_type want;
   } stim_row_type;

   localparam logic [63:0] KEY_A1 = {"A1", 48'h0};
   localparam logic [63:0] KEY_B2 = {"B2", 48'h0};
   localparam logic [63:0] KEY_C3 = {"C3", 48'h0};
   localparam logic [63:0] ONES   = '1;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;

   logic [63:0]     held_keys [CAPACITY];
   logic [63:0]     held_pays [CAPACITY];
   int              held_count = 0;
   queue_rsp_type   pending_rsps [$];
   stim_row_type    directed_rows [$];
   int              idle_pct = 0;
   int              stall_pct = 0;
   int              errors = 0;

   sorted_bounded_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #3_200_000;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Pushes go after every held entry with an equal key, so equal keys leave
   // in arrival order.
   function automatic queue_rsp_type apply_to_queue(input act_type act,
                                                    input logic [63:0] key,
                                                    input logic [63:0] pay);
      queue_rsp_type r;
      int i;
      r.status = STATUS_DONE;
      r.key = '0;
      r.pay = '0;
      if (act == ACT_PUSH) begin
         if (held_count >= CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            i = held_count;
            while (i > 0 && held_keys[i-1] > key) begin
               held_keys[i] = held_keys[i-1];
               held_pays[i] = held_pays[i-1];
               i--;
            end
            held_keys[i] = key;
            held_pays[i] = pay;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.key = held_keys[0];
            r.pay = held_pays[0];
            for (i = 1; i < held_count; i++) begin
               held_keys[i-1] = held_keys[i];
               held_pays[i-1] = held_pays[i];
            end
            held_count--;
         end
      end
      r.fill = held_count[3:0];
      return r;
   endfunction

   function automatic void add_row(input act_type act, input logic [63:0] key,
                                   input logic [63:0] pay, input bit typed,
                                   input status_type status = STATUS_DONE,
                                   input logic [63:0] pkey = '0,
                                   input logic [63:0] ppay = '0,
                                   input logic [3:0] fill = '0);
      stim_row_type row;
      row.act = act;
      row.key = key;
      row.pay = pay;
      row.typed = typed;
      row.want.status = status;
      row.want.key = pkey;
      row.want.pay = ppay;
      row.want.fill = fill;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [63:0] pick_key();
      int sel;
      logic [7:0] c1;
      logic [7:0] c2;
      sel = $urandom_range(99);
      c1 = 8'h41 + 8'($urandom_range(3));
      c2 = 8'h30 + 8'($urandom_range(9));
      if (sel < 45) begin
         return {c1, c2, 48'h0};
      end else if (sel < 55) begin
         return sel[0] ? ONES : 64'h0;
      end
      return {$urandom, $urandom};
   endfunction

   // Offers one request beat, idling first at the current rate, and returns
   // at the edge where it is taken; the expected response is queued there.
   task automatic send_item(input act_type act, input logic [63:0] key,
                            input logic [63:0] pay, input bit typed,
                            input queue_rsp_type want);
      queue_rsp_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {pay, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_to_queue(act, key, pay);
      pending_rsps.push_back(typed ? want : predicted);
   endtask

   always @(posedge clock) begin
      queue_rsp_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: response beat with none expected: status %0d data %h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            exp_rsp = pending_rsps.pop_front();
            if (rsp_tuser !== exp_rsp.status || rsp_tdata[63:0] !== exp_rsp.key ||
                rsp_tdata[127:64] !== exp_rsp.pay || rsp_tdata[131:128] !== exp_rsp.fill ||
                rsp_tdata[135:132] !== 4'h0) begin
               $display("%0t: expected status %0d key %h payload %h fill %0d",
                        $time, exp_rsp.status, exp_rsp.key, exp_rsp.pay, exp_rsp.fill);
               $display("%0t: actual   status %0d key %h payload %h fill %0d pad %h",
                        $time, rsp_tuser, rsp_tdata[63:0], rsp_tdata[127:64],
                        rsp_tdata[131:128], rsp_tdata[135:132]);
               errors++;
            end
         end
      end
   end

   initial begin
      queue_rsp_type none;
      act_type act;
      int push_pct;
      int burst;
      int sent;
      none = '{STATUS_DONE, 64'h0, 64'h0, 4'h0};

      add_row(ACT_POP, '0, '0, 1, STATUS_EMPTY, '0, '0, 4'd0);
      add_row(ACT_PUSH, ONES, '0, 1, STATUS_DONE, '0, '0, 4'd1);
      add_row(ACT_PUSH, '0, ONES, 1, STATUS_DONE, '0, '0, 4'd2);
      add_row(ACT_POP, '0, '0, 1, STATUS_DONE, '0, ONES, 4'd1);
      add_row(ACT_POP, ONES, ONES, 1, STATUS_DONE, ONES, '0, 4'd0);
      add_row(ACT_POP, ONES, ONES, 1, STATUS_EMPTY, '0, '0, 4'd0);
      add_row(ACT_PUSH, KEY_B2, {"NAME0", 24'h0}, 0);
      add_row(ACT_PUSH, KEY_A1, {"NAME1", 24'h0}, 0);
      add_row(ACT_PUSH, KEY_B2, {"NAME2", 24'h0}, 0);
      add_row(ACT_PUSH, KEY_C3, {"NAME3", 24'h0}, 0);
      add_row(ACT_PUSH, KEY_A1, {"NAME4", 24'h0}, 0);
      add_row(ACT_PUSH, KEY_B2, {"NAME5", 24'h0}, 0);
      add_row(ACT_PUSH, '0, {"NAME6", 24'h0}, 0);
      add_row(ACT_PUSH, ONES, {"NAME7", 24'h0}, 0);
      add_row(ACT_PUSH, KEY_A1, {"NAME8", 24'h0}, 0);
      add_row(ACT_PUSH, KEY_B2, {"NAME9", 24'h0}, 0);
      add_row(ACT_PUSH, KEY_C3, ONES, 1, STATUS_FULL, '0, '0, 4'd10);
      for (int i = 0; i < 5; i++) add_row(ACT_POP, '0, '0, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].act, directed_rows[i].key, directed_rows[i].pay,
                   directed_rows[i].typed, directed_rows[i].want);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 51; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 7; stall_pct = 7; end
         endcase
         sent = 0;
         while (sent < 357) begin
            // Bursts are push-heavy, pop-heavy or balanced, so the queue swings between
            // full and empty.
            case ($urandom_range(2))
               0: push_pct = 15;
               1: push_pct = 50;
               default: push_pct = 85;
            endcase
            burst = $urandom_range(60, 20);
            for (int k = 0; k < burst && sent < 357; k++) begin
               act = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
               send_item(act, pick_key(), {$urandom, $urandom}, 0, none);
               sent++;
            end
         end
      end
      req_tvalid <= 1'b0;

      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
